/* design/block_transposition_cipher_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the columnar transposition cipher
// Expects clk and rst in the scope where a macro is used.
// ---------------------------------------------------------------------------
`ifndef BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH
`define BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/btc_pkg.sv */
// ---------------------------------------------------------------------------
// btc_pkg
// Shared types, constants and byte helpers of the transposition cipher.
// ---------------------------------------------------------------------------
`default_nettype none

package btc_pkg;

  // Default buffer depth in bytes
  localparam int MAX_LEN_DEF = 64;

  // Fixed field widths
  localparam int KEY_W  = 6;
  localparam int WIDE_W = KEY_W + 1;
  localparam int DATA_W = KEY_W;

  // Configuration register indexes
  localparam logic REG_KEY_WIDTH    = 1'b0;
  localparam logic REG_DECRYPT_MODE = 1'b1;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_KEY      = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Pad byte
  localparam logic [7:0] PAD_CHAR = 8'h78;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
    logic [1:0] error_code;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_SETUP,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       err_valid;
    logic [1:0] err_code;
    logic       div_load;
    logic       div_step;
    logic       setup;
    logic       emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic overflow;
    logic key_bad;
    logic div_last;
    logic pad_err;
    logic emit_last;
  } stat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Keep decision on an already lower-cased byte
  function automatic logic keep_byte(input logic [7:0] c, input logic decrypt);
    logic k;
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
      k = 1'b0;
    end else if (!decrypt) begin
      k = (c >= 8'h61 && c <= 8'h7a);
    end else begin
      k = 1'b1;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/block_transposition_cipher.sv */
// ---------------------------------------------------------------------------
// block_transposition_cipher
// Columnar transposition cipher taking one message byte per request.
// ---------------------------------------------------------------------------
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   ----------------------
//   request   req.char_in, req.end_of_message        start & !busy
//   result    result.char_out/last_out/error_code    result_strobe, 1 cycle
//   config    cfg_index, cfg_data                    cfg_write, no wait
//
// A byte without the end mark is taken while idle; busy stays low.
// The end byte starts a check state, then a divide of length by key, a
// setup state and a burst of rows*cols results, one result per cycle from
// the single buffer read port. An error result is registered from the
// check state, or from the setup state for a pad overflow.
// Results cannot be held off, so only busy stalls the sender.
// Reset is synchronous; the buffer has no reset and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module block_transposition_cipher #(
  parameter int MAX_LEN = btc_pkg::MAX_LEN_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  btc_pkg::req_t               req,
  output logic                        busy,
  output btc_pkg::rsp_t               result,
  output logic                        result_strobe,
  input  wire                         cfg_write,
  input  wire                         cfg_index,
  input  wire  [btc_pkg::DATA_W-1:0]  cfg_data
);

  btc_pkg::cmd_t  cmd;
  btc_pkg::stat_t stat;

  btc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .eom   (req.end_of_message),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  btc_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req           (req),
    .cmd           (cmd),
    .stat          (stat),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

`default_nettype wire

/* design/btc_datapath.sv */
// ---------------------------------------------------------------------------
// btc_datapath
// Text buffer, length divider, transposition address walk and result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module btc_datapath #(
  parameter int MAX_LEN = btc_pkg::MAX_LEN_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_write,
  input  wire               cfg_index,
  input  wire  [btc_pkg::DATA_W-1:0] cfg_data,
  input  btc_pkg::req_t     req,
  input  btc_pkg::cmd_t     cmd,
  output btc_pkg::stat_t    stat,
  output btc_pkg::rsp_t     result,
  output logic              result_strobe
);

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int STEP_W = $clog2(CNT_W);
  localparam int WIDE_W = btc_pkg::WIDE_W;
  localparam int KEY_W  = btc_pkg::KEY_W;

  // Configuration
  logic [KEY_W-1:0] key;
  logic             mode;

  // Message state
  logic [7:0]       mem [MAX_LEN];
  logic [CNT_W-1:0] kept;
  logic             ovf;

  // Divider
  logic [WIDE_W-1:0] rem;
  logic [CNT_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [WIDE_W-1:0] trial;
  logic [WIDE_W-1:0] key_w;

  // Address walk
  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cols;
  logic [CNT_W-1:0] col_i;
  logic [CNT_W-1:0] row_j;
  logic [CNT_W-1:0] idx;

  // Result registers
  logic       out_last;
  logic [1:0] out_err;
  logic       out_pad;
  logic [7:0] rd_q;

  logic [7:0]        ch_low;
  logic              keep;
  logic              rem_nz;
  logic [WIDE_W:0]   padded;
  logic [CNT_W-1:0]  rows_enc;

  assign ch_low = btc_pkg::to_lower(req.char_in);
  assign keep   = btc_pkg::keep_byte(ch_low, mode);
  assign key_w  = {1'b0, key};
  assign trial  = {rem[WIDE_W-2:0], quo[CNT_W-1]};
  assign rem_nz = (rem != '0);
  assign rows_enc = quo + CNT_W'(rem_nz);
  assign padded = (WIDE_W+1)'(kept) + (rem_nz ? (WIDE_W+1)'(key_w - rem) : '0);

  // Status toward the controller
  assign stat.overflow  = ovf;
  assign stat.key_bad   = (key == '0) || (key_w >= WIDE_W'(kept));
  assign stat.div_last  = (step == STEP_W'(CNT_W - 1));
  assign stat.pad_err   = !mode && (padded > (WIDE_W+1)'(MAX_LEN));
  assign stat.emit_last = (col_i == cols - 1'b1) && (row_j == rows - 1'b1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= KEY_W'(1);
      mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        btc_pkg::REG_KEY_WIDTH:    key  <= cfg_data[KEY_W-1:0];
        btc_pkg::REG_DECRYPT_MODE: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Track kept length and overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      kept <= '0;
      ovf  <= 1'b0;
    end else if (cmd.accept && keep) begin
      if (kept < CNT_W'(MAX_LEN)) begin
        kept <= kept + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && keep && (kept < CNT_W'(MAX_LEN))) begin
      mem[kept[ADDR_W-1:0]] <= ch_low;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rd_q <= mem[idx[ADDR_W-1:0]];
    end
  end

  // Restoring divide of length by key, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= '0;
      quo  <= kept;
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      if (trial >= key_w) begin
        rem <= trial - key_w;
        quo <= {quo[CNT_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[CNT_W-2:0], 1'b0};
      end
    end
  end

  // Walk the buffer column by column
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (mode) begin
        rows <= CNT_W'(key);
        cols <= quo;
      end else begin
        rows <= rows_enc;
        cols <= CNT_W'(key);
      end
      col_i <= '0;
      row_j <= '0;
      idx   <= '0;
    end else if (cmd.emit) begin
      if (row_j == rows - 1'b1) begin
        row_j <= '0;
        col_i <= col_i + 1'b1;
        idx   <= col_i + 1'b1;
      end else begin
        row_j <= row_j + 1'b1;
        idx   <= idx + cols;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit || cmd.err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_valid) begin
      out_last <= 1'b1;
      out_err  <= cmd.err_code;
      out_pad  <= 1'b0;
    end else if (cmd.emit) begin
      out_last <= stat.emit_last;
      out_err  <= btc_pkg::ERR_NONE;
      out_pad  <= (idx >= kept);
    end
  end

  // Zero the byte on error, substitute pad past the text
  always_comb begin
    result.last_out   = out_last;
    result.error_code = out_err;
    if (out_err != btc_pkg::ERR_NONE) begin
      result.char_out = 8'h00;
    end else if (out_pad) begin
      result.char_out = btc_pkg::PAD_CHAR;
    end else begin
      result.char_out = rd_q;
    end
  end

endmodule

`default_nettype wire

/* design/btc_ctrl.sv */
// ---------------------------------------------------------------------------
// btc_ctrl
// Sequencer: accept bytes, check, divide, set up and run the output burst.
// ---------------------------------------------------------------------------
`default_nettype none

module btc_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  wire            eom,
  input  btc_pkg::stat_t stat,
  output logic           busy,
  output btc_pkg::cmd_t  cmd
);

  btc_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      btc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (eom) begin
            state_next = btc_pkg::S_CHECK;
          end
        end
      end
      btc_pkg::S_CHECK: begin
        if (stat.overflow) begin
          cmd.err_valid = 1'b1;
          cmd.err_code  = btc_pkg::ERR_OVERFLOW;
          cmd.clear     = 1'b1;
          state_next    = btc_pkg::S_IDLE;
        end else if (stat.key_bad) begin
          cmd.err_valid = 1'b1;
          cmd.err_code  = btc_pkg::ERR_KEY;
          cmd.clear     = 1'b1;
          state_next    = btc_pkg::S_IDLE;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = btc_pkg::S_DIVIDE;
        end
      end
      btc_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = btc_pkg::S_SETUP;
        end
      end
      btc_pkg::S_SETUP: begin
        if (stat.pad_err) begin
          cmd.err_valid = 1'b1;
          cmd.err_code  = btc_pkg::ERR_OVERFLOW;
          cmd.clear     = 1'b1;
          state_next    = btc_pkg::S_IDLE;
        end else begin
          cmd.setup  = 1'b1;
          state_next = btc_pkg::S_EMIT;
        end
      end
      btc_pkg::S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) begin
          cmd.clear  = 1'b1;
          state_next = btc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = btc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/btc_checker.sv */
// ---------------------------------------------------------------------------
// btc_checker
// Port-level checks of request acceptance and result bursts.
// ---------------------------------------------------------------------------
`default_nettype none

`include "block_transposition_cipher_assert.svh"

module btc_checker (
  input wire           clk,
  input wire           rst,
  input wire           start,
  input btc_pkg::req_t req,
  input wire           busy,
  input btc_pkg::rsp_t result,
  input wire           result_strobe
);

  // Accepted request never yields a result in the next cycle
  `BTC_ASSERT_NEXT(a_no_quick_result, start && !busy, !result_strobe, "result right after request")

  // End byte moves the block to busy
  `BTC_ASSERT_NEXT(a_end_busy, start && !busy && req.end_of_message, busy, "end byte not busy")

  // Burst runs without gaps up to its last result
  `BTC_ASSERT_NEXT(a_burst_gapless, result_strobe && !result.last_out, result_strobe, "burst gap")

  // Block stays busy inside a burst
  `BTC_ASSERT_NOW(a_burst_busy, result_strobe && !result.last_out, busy, "idle in burst")

  // Error result is a single zero byte
  `BTC_ASSERT_NOW(a_err_form, result_strobe && (result.error_code != btc_pkg::ERR_NONE), (result.char_out == 8'h00) && result.last_out, "bad error result")

endmodule

bind block_transposition_cipher btc_checker u_btc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .req           (req),
  .busy          (busy),
  .result        (result),
  .result_strobe (result_strobe)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: columnar transposition cipher testbench
// Feeds message bytes through the start/busy request port and checks every
// strobed result against a byte-level model of the cipher. The model keeps
// its own kept-text buffer, key and mode. Runs a short directed set first,
// then a few long messages for the buffer limits, then random phases with
// random keys, modes and sender gaps.
// ---------------------------------------------------------------------------

module tb_top;

  localparam int ITEM_TARGET   = 380;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  // Model of the cipher plus the queue of results still owed by the block
  class cipher_tracker;
    logic [7:0]                text [btc_pkg::MAX_LEN_DEF];
    int unsigned               kept;
    bit                        overflowed;
    logic [btc_pkg::KEY_W-1:0] key;
    bit                        decrypt;
    btc_pkg::rsp_t             expected_q [$];
    int unsigned               failures;

    function new();
      kept       = 0;
      overflowed = 0;
      key        = 1;
      decrypt    = 0;
      failures   = 0;
    endfunction

    function void write_reg(logic idx, logic [btc_pkg::DATA_W-1:0] val);
      if (idx == btc_pkg::REG_KEY_WIDTH) begin
        key = val[btc_pkg::KEY_W-1:0];
      end else begin
        decrypt = val[0];
      end
    endfunction

    // Apply one accepted byte; returns 1 if the byte did anything
    function bit note_byte(btc_pkg::req_t r);
      logic [7:0]    c;
      logic [1:0]    err;
      bit            keep;
      int unsigned   rows, cols, idx, i, j;
      btc_pkg::rsp_t o;
      c = r.char_in;
      if (c >= 8'h41 && c <= 8'h5a) begin
        c = c + 8'h20;
      end
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
        keep = 0;
      end else if (!decrypt) begin
        keep = (c >= 8'h61 && c <= 8'h7a);
      end else begin
        keep = 1;
      end
      if (keep) begin
        if (kept < btc_pkg::MAX_LEN_DEF) begin
          text[kept] = c;
          kept++;
        end else begin
          overflowed = 1;
        end
      end
      if (!r.end_of_message) begin
        return keep;
      end

      // End of message: work out the whole burst
      err  = btc_pkg::ERR_NONE;
      rows = 0;
      cols = 0;
      if (overflowed) begin
        err = btc_pkg::ERR_OVERFLOW;
      end else if (key == 0 || key >= kept) begin
        err = btc_pkg::ERR_KEY;
      end else if (!decrypt) begin
        cols = key;
        rows = (kept + key - 1) / key;
        if (rows * cols > btc_pkg::MAX_LEN_DEF) begin
          err = btc_pkg::ERR_OVERFLOW;
        end
      end else begin
        rows = key;
        cols = kept / key;
      end

      if (err != btc_pkg::ERR_NONE) begin
        o.char_out   = 8'h00;
        o.last_out   = 1'b1;
        o.error_code = err;
        expected_q   = {expected_q, o};
      end else begin
        // Read out column by column, padding past the kept text
        for (i = 0; i < cols; i++) begin
          for (j = 0; j < rows; j++) begin
            idx          = j * cols + i;
            o.char_out   = (idx < kept) ? text[idx] : btc_pkg::PAD_CHAR;
            o.last_out   = (i == cols - 1) && (j == rows - 1);
            o.error_code = btc_pkg::ERR_NONE;
            expected_q   = {expected_q, o};
          end
        end
      end
      kept       = 0;
      overflowed = 0;
      return 1;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%s", msg);
      end
    endfunction

    function void check_output(btc_pkg::rsp_t got);
      btc_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: char %h last %b err %0d",
                       got.char_out, got.last_out, got.error_code));
        return;
      end
      want = expected_q.pop_front();
      if (got.char_out !== want.char_out || got.last_out !== want.last_out ||
          got.error_code !== want.error_code) begin
        flag($sformatf("mismatch: exp char %h last %b err %0d, got char %h last %b err %0d",
                       want.char_out, want.last_out, want.error_code,
                       got.char_out, got.last_out, got.error_code));
      end
    endfunction

    // Count every result that never arrived
    function void flush_missing();
      btc_pkg::rsp_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        flag($sformatf("missing result: expected char %h last %b err %0d",
                       want.char_out, want.last_out, want.error_code));
      end
    endfunction
  endclass

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       start         = 1'b0;
  btc_pkg::req_t              req           = '0;
  logic                       busy;
  btc_pkg::rsp_t              result;
  logic                       result_strobe;
  logic                       cfg_write     = 1'b0;
  logic                       cfg_index     = 1'b0;
  logic [btc_pkg::DATA_W-1:0] cfg_data      = '0;

  cipher_tracker              board         = new();
  logic [7:0]                 msg_q [$];
  int unsigned                counted_bytes = 0;
  int unsigned                burst_left    = 0;

  block_transposition_cipher u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req           (req),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check each strobed result
  always @(posedge clk) begin
    if (!rst && result_strobe !== 1'b0) begin
      board.check_output(result);
    end
  end

  // Hard stop on a hung run
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("block_transposition_cipher test failed");
    $finish;
  end

  // Write both registers back to back; the block must be idle
  task automatic set_config(input logic [btc_pkg::KEY_W-1:0] key_val, input logic mode_val);
    cfg_write <= 1'b1;
    cfg_index <= btc_pkg::REG_KEY_WIDTH;
    cfg_data  <= key_val;
    @(posedge clk);
    board.write_reg(btc_pkg::REG_KEY_WIDTH, key_val);
    cfg_index <= btc_pkg::REG_DECRYPT_MODE;
    cfg_data  <= {{(btc_pkg::DATA_W-1){1'b0}}, mode_val};
    @(posedge clk);
    board.write_reg(btc_pkg::REG_DECRYPT_MODE, {{(btc_pkg::DATA_W-1){1'b0}}, mode_val});
    cfg_write <= 1'b0;
  endtask

  // Hold the request until it is taken; start stays high on return
  task automatic send_item(input btc_pkg::req_t r);
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (board.note_byte(r)) begin
      counted_bytes++;
    end
  endtask

  // Drop start for a random gap at the end of each burst
  task automatic pace(input bit paced);
    if (paced && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic send_message(input bit paced);
    btc_pkg::req_t r;
    for (int k = 0; k < msg_q.size(); k++) begin
      pace(paced);
      r.char_in        = msg_q[k];
      r.end_of_message = (k == msg_q.size() - 1);
      send_item(r);
    end
  endtask

  // Wait until every owed result has come, then let the block go idle
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (board.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    board.flush_missing();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_byte(input bit letters_only);
    logic [7:0]  b;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    b    = 8'h61 + 8'($urandom_range(0, 25));
    if (pick < 6) begin
      b = b - 8'h20;
    end else if (!letters_only && pick >= 13 && pick < 16) begin
      b = ($urandom_range(0, 5) == 5) ? 8'h20 : 8'h09 + 8'($urandom_range(0, 4));
    end else if (!letters_only && pick >= 16) begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic void build_message(input int unsigned len, input bit letters_only);
    msg_q.delete();
    repeat (len) msg_q = {msg_q, random_byte(letters_only)};
  endfunction

  initial begin : stimulus
    int unsigned key_val;
    int unsigned len;
    int unsigned n_msgs;
    int unsigned key_pick;
    bit          mode_val;
    bit          paced;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: key 1, encrypt; upper case folds down
    msg_q = '{8'h41, 8'h62};
    send_message(1'b0);
    settle();
    // Empty message: only whitespace
    msg_q = '{8'h20};
    send_message(1'b0);
    settle();
    // Key zero
    set_config(0, 1'b0);
    msg_q = '{8'h61, 8'h62};
    send_message(1'b0);
    settle();
    // Encrypt filter around the letter ranges, with padding
    set_config(3, 1'b0);
    msg_q = '{8'h48, 8'h40, 8'h65, 8'h09, 8'h5b, 8'h6c, 8'hff, 8'h60,
              8'h5a, 8'h00, 8'h7b, 8'h71};
    send_message(1'b0);
    settle();
    // Decrypt keeps high bytes and digits; end mark on a dropped byte
    set_config(2, 1'b1);
    msg_q = '{8'h80, 8'hff, 8'h41, 8'h30, 8'h0d, 8'h20};
    send_message(1'b0);
    settle();
    // Largest key, not below the length
    set_config(63, 1'b1);
    msg_q = '{8'h7a, 8'h7b};
    send_message(1'b0);
    settle();

    // Padding that no longer fits the buffer
    set_config(5, 1'b0);
    build_message(63, 1'b1);
    send_message(1'b1);
    settle();
    // Full buffer, largest key: one column of 63 rows
    set_config(63, 1'b1);
    build_message(64, 1'b1);
    send_message(1'b1);
    settle();
    // Kept bytes past the buffer
    set_config(4, 1'b0);
    build_message(66, 1'b1);
    send_message(1'b1);
    settle();

    // Random phases: one setting, a few messages, then drain
    while (counted_bytes < ITEM_TARGET) begin
      key_pick = $urandom_range(0, 9);
      if (key_pick < 5) begin
        key_val = $urandom_range(1, 6);
      end else if (key_pick < 7) begin
        key_val = $urandom_range(7, 15);
      end else if (key_pick == 7) begin
        key_val = 63;
      end else if (key_pick == 8) begin
        key_val = $urandom_range(0, 63);
      end else begin
        key_val = $urandom_range(2, 4);
      end
      mode_val = 1'($urandom_range(0, 1));
      set_config(key_val[btc_pkg::KEY_W-1:0], mode_val);
      paced  = ($urandom_range(0, 3) != 0);
      n_msgs = $urandom_range(1, 4);
      repeat (n_msgs) begin
        if ($urandom_range(0, 11) == 0) begin
          len = $urandom_range(58, 70);
        end else begin
          len = $urandom_range(1, (key_val < 20) ? key_val + 10 : 30);
        end
        build_message(len, len > 50 || $urandom_range(0, 3) == 0);
        send_message(paced);
      end
      settle();
    end

    if (board.failures == 0) begin
      $display("block_transposition_cipher test passed");
    end else begin
      $display("block_transposition_cipher test failed");
    end
    $finish;
  end

endmodule
